[design/sdss_pkg.sv]
`default_nettype none
package sdss_pkg;

	// Q1.14 constants (unsigned)
	localparam logic [14:0] ONE_Q14   = 15'd16384;
	localparam logic [14:0] LIMIT_Q14 = 15'd16220;

	localparam logic [7:0] MANUAL_NAV_CODE = 8'd0;
	localparam logic [2:0] RC_SOURCE_CODE  = 3'd1;

	// serial multiplier: A operand, B operand (shifted one bit a cycle), product
	localparam int MUL_AW = 43;
	localparam int MUL_BW = 15;
	localparam int MUL_PW = MUL_AW + MUL_BW;

	// serial divider: dividend / quotient width, divisor width
	localparam int DIV_NW = 43;
	localparam int DIV_DW = 29;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_ENABLE    = 3'd0,
		CFG_DEADZONE  = 3'd1,
		CFG_EXPO      = 3'd2,
		CFG_SUPEREXPO = 3'd3,
		CFG_GAIN      = 3'd4,
		CFG_TIMEOUT   = 3'd5
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV1,
		ST_MUL_D2,
		ST_MUL_D3,
		ST_MUL_T,
		ST_MUL_EV,
		ST_MUL_NUM,
		ST_MUL_DS,
		ST_DIV2,
		ST_MUL_G,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [47:0]        now_time;
		logic [47:0]        mode_time;
		logic [7:0]         nav_state;
		logic [5:0]         mode_flags;
		logic [2:0]         sample_source;
		logic [1:0]         stick_flags;
		logic [47:0]        stick_time;
		logic [47:0]        sample_time;
		logic signed [15:0] throttle_axis;
		logic signed [15:0] yaw_axis;
	} in_item_t;

	typedef struct packed {
		logic               request_valid;
		logic signed [15:0] longitudinal;
		logic signed [15:0] steering;
		logic [31:0]        sequence_number;
		logic [47:0]        sample_stamp;
	} out_item_t;

endpackage
`default_nettype wire

[design/sdss_mul.sv]
`default_nettype none
module sdss_mul (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [sdss_pkg::MUL_AW-1:0] a,
	input  wire logic [sdss_pkg::MUL_BW-1:0] b,
	output logic                            done,
	output logic [sdss_pkg::MUL_PW-1:0]     p
);
	import sdss_pkg::*;

	localparam int CW = $clog2(MUL_BW + 1);

	logic [MUL_PW-1:0] acc_q;
	logic [MUL_PW-1:0] a_sh_q;
	logic [MUL_BW-1:0] b_q;
	logic [CW-1:0]     cnt_q;
	logic              done_q;

	// control: bit counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && (cnt_q == CW'(1));
			if (start)
				cnt_q <= CW'(MUL_BW);
			else if (cnt_q != '0)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	// shift-add, one multiplier bit per cycle, LSB first
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q  <= '0;
			a_sh_q <= MUL_PW'(a);
			b_q    <= b;
		end else if (cnt_q != '0) begin
			if (b_q[0])
				acc_q <= acc_q + a_sh_q;
			a_sh_q <= a_sh_q << 1;
			b_q    <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule
`default_nettype wire

[design/sdss_div.sv]
`default_nettype none
module sdss_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [sdss_pkg::DIV_NW-1:0] n,
	input  wire logic [sdss_pkg::DIV_DW-1:0] d,
	output logic                             done,
	output logic [sdss_pkg::DIV_NW-1:0]      q
);
	import sdss_pkg::*;

	localparam int CW = $clog2(DIV_NW + 1);

	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] dvs_q;
	logic [DIV_NW-1:0] nq_q;
	logic [CW-1:0]     cnt_q;
	logic              done_q;
	logic [DIV_DW:0]   trial;

	assign trial = {rem_q, nq_q[DIV_NW-1]};

	// control: bit counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && (cnt_q == CW'(1));
			if (start)
				cnt_q <= CW'(DIV_NW);
			else if (cnt_q != '0)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	// restoring division, one quotient bit per cycle; quotient shifts into nq_q
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= d;
			nq_q  <= n;
		end else if (cnt_q != '0) begin
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= DIV_DW'(trial - {1'b0, dvs_q});
				nq_q  <= {nq_q[DIV_NW-2:0], 1'b1};
			end else begin
				rem_q <= trial[DIV_DW-1:0];
				nq_q  <= {nq_q[DIV_NW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign q    = nq_q;

endmodule
`default_nettype wire

[design/stick_deadzone_superexpo_shaper_top.sv]
`default_nettype none
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_stall    in_data  (in_item_t)
// out       output     out_valid / out_stall  out_data (out_item_t)
// cfg       input      cfg_we                 cfg_index, cfg_data
//
// One item at a time. An invalid item, or yaw inside the deadzone, goes from the
// accept step straight to the output step. A shaped item passes the accept step, a
// serial divide for the deadzone scale, seven serial multiplies, a serial divide
// for superexpo and the output step (each unit is its bit steps plus a handoff).
// in_stall is high whenever an item is in work; a finished result sits in the
// output register while the next item is taken. Reset is asynchronous, active low.
module stick_deadzone_superexpo_shaper_top (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire sdss_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output sdss_pkg::out_item_t      out_data,
	input  wire logic                cfg_we,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [23:0]         cfg_data
);
	import sdss_pkg::*;

	// configuration registers
	logic        enable_q;
	logic [14:0] deadzone_q, expo_q, superexpo_q, gain_q;
	logic [23:0] timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			deadzone_q  <= '0;
			expo_q      <= '0;
			superexpo_q <= '0;
			gain_q      <= ONE_Q14;
			timeout_q   <= 24'd500000;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ENABLE:    enable_q    <= cfg_data[0];
				CFG_DEADZONE:  deadzone_q  <= cfg_data[14:0];
				CFG_EXPO:      expo_q      <= cfg_data[14:0];
				CFG_SUPEREXPO: superexpo_q <= cfg_data[14:0];
				CFG_GAIN:      gain_q      <= cfg_data[14:0];
				CFG_TIMEOUT:   timeout_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// saturated shaping parameters
	logic [14:0] w_c, e_c, s_c, den1_c;
	assign w_c    = (deadzone_q > LIMIT_Q14) ? LIMIT_Q14 : deadzone_q;
	assign e_c    = (expo_q > ONE_Q14) ? ONE_Q14 : expo_q;
	assign s_c    = (superexpo_q > LIMIT_Q14) ? LIMIT_Q14 : superexpo_q;
	assign den1_c = ONE_Q14 - w_c;

	// gating on the incoming item
	logic        mode_ok, stick_ok, item_ok;
	logic [47:0] age;
	logic [16:0] yaw_abs;
	logic [14:0] mag_c;

	assign age = in_data.now_time - in_data.mode_time;
	assign mode_ok = in_data.mode_flags[0] && (in_data.mode_time != '0) &&
		(in_data.mode_time <= in_data.now_time) && (age <= 48'(timeout_q)) &&
		(in_data.nav_state == MANUAL_NAV_CODE) && in_data.mode_flags[2] &&
		!in_data.mode_flags[3] && !in_data.mode_flags[4] && !in_data.mode_flags[5];
	assign stick_ok = in_data.stick_flags[0] && in_data.stick_flags[1] &&
		(in_data.sample_source == RC_SOURCE_CODE) &&
		(in_data.stick_time != '0) && (in_data.sample_time != '0) &&
		(in_data.sample_time <= in_data.stick_time) &&
		(in_data.stick_time <= in_data.now_time) &&
		(in_data.throttle_axis >= -16'sd16384) && (in_data.throttle_axis <= 16'sd16384) &&
		(in_data.yaw_axis >= -16'sd16384) && (in_data.yaw_axis <= 16'sd16384);
	assign item_ok = enable_q && mode_ok && stick_ok;
	assign yaw_abs = in_data.yaw_axis[15] ? 17'(-17'(in_data.yaw_axis)) :
		17'(in_data.yaw_axis);
	assign mag_c = yaw_abs[14:0];

	// shared serial units
	logic              mul_go, mul_done;
	logic [MUL_AW-1:0] mul_a;
	logic [MUL_BW-1:0] mul_b;
	logic [MUL_PW-1:0] mul_p;
	logic              div_go, div_done;
	logic [DIV_NW-1:0] div_n, div_q;
	logic [DIV_DW-1:0] div_d;

	sdss_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_go), .a(mul_a), .b(mul_b),
		.done(mul_done), .p(mul_p)
	);

	sdss_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go), .n(div_n), .d(div_d),
		.done(div_done), .q(div_q)
	);

	// item registers
	state_t             state_q, state_d;
	logic               valid_q, neg_q;
	logic signed [15:0] thr_q;
	logic [47:0]        samp_q;
	logic [14:0]        d_q, steer_q;
	logic [29:0]        tr_q;
	logic [MUL_PW-1:0]  num_q;
	logic               out_valid_q;
	out_item_t          out_q;
	logic [31:0]        count_q;

	// intermediate values
	logic [14:0]       d_c, g_c;
	logic [29:0]       ev_c;
	logic [28:0]       den2_c;
	logic [MUL_PW-1:0] g_full;

	assign d_c    = (div_q > DIV_NW'(ONE_Q14)) ? ONE_Q14 : div_q[14:0];
	assign ev_c   = 30'(mul_p) + tr_q;
	assign den2_c = 29'(29'd1 << 28) - 29'(mul_p);
	assign g_full = (mul_p + MUL_PW'(8192)) >> 14;
	assign g_c    = (g_full > MUL_PW'(ONE_Q14)) ? ONE_Q14 : g_full[14:0];

	logic out_free;
	assign out_free = !out_valid_q || !out_stall;

	// sequencer: next state and unit launches
	always_comb begin
		state_d = state_q;
		mul_go  = 1'b0;
		mul_a   = '0;
		mul_b   = '0;
		div_go  = 1'b0;
		div_n   = '0;
		div_d   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (item_ok && (mag_c > w_c)) begin
						div_go  = 1'b1;
						div_n   = DIV_NW'({15'(mag_c - w_c), 14'b0}) +
							DIV_NW'(den1_c >> 1);
						div_d   = DIV_DW'(den1_c);
						state_d = ST_DIV1;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_DIV1: begin
				if (div_done) begin
					mul_go  = 1'b1;
					mul_a   = MUL_AW'(d_c);
					mul_b   = d_c;
					state_d = ST_MUL_D2;
				end
			end
			ST_MUL_D2: begin
				if (mul_done) begin
					mul_go  = 1'b1;
					mul_a   = MUL_AW'(mul_p);
					mul_b   = d_q;
					state_d = ST_MUL_D3;
				end
			end
			ST_MUL_D3: begin
				if (mul_done) begin
					mul_go  = 1'b1;
					mul_a   = MUL_AW'(mul_p);
					mul_b   = e_c;
					state_d = ST_MUL_T;
				end
			end
			ST_MUL_T: begin
				if (mul_done) begin
					mul_go  = 1'b1;
					mul_a   = MUL_AW'(d_q);
					mul_b   = ONE_Q14 - e_c;
					state_d = ST_MUL_EV;
				end
			end
			ST_MUL_EV: begin
				if (mul_done) begin
					mul_go  = 1'b1;
					mul_a   = MUL_AW'(ev_c);
					mul_b   = ONE_Q14 - s_c;
					state_d = ST_MUL_NUM;
				end
			end
			ST_MUL_NUM: begin
				if (mul_done) begin
					mul_go  = 1'b1;
					mul_a   = MUL_AW'(d_q);
					mul_b   = s_c;
					state_d = ST_MUL_DS;
				end
			end
			ST_MUL_DS: begin
				if (mul_done) begin
					div_go  = 1'b1;
					div_n   = DIV_NW'(num_q) + DIV_NW'(den2_c >> 1);
					div_d   = den2_c;
					state_d = ST_DIV2;
				end
			end
			ST_DIV2: begin
				if (div_done) begin
					mul_go  = 1'b1;
					mul_a   = MUL_AW'(div_q);
					mul_b   = gain_q;
					state_d = ST_MUL_G;
				end
			end
			ST_MUL_G: begin
				if (mul_done)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
				count_q     <= count_q + 32'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			valid_q <= item_ok;
			neg_q   <= in_data.yaw_axis[15];
			thr_q   <= in_data.throttle_axis;
			samp_q  <= in_data.sample_time;
			steer_q <= '0;
		end
		if (state_q == ST_DIV1 && div_done)
			d_q <= d_c;
		if (state_q == ST_MUL_T && mul_done)
			tr_q <= 30'((mul_p + MUL_PW'(1) * (MUL_PW'(1) << 27)) >> 28);
		if (state_q == ST_MUL_NUM && mul_done)
			num_q <= mul_p;
		if (state_q == ST_MUL_G && mul_done)
			steer_q <= g_c;
		if (state_q == ST_DONE && out_free) begin
			out_q.request_valid   <= valid_q;
			out_q.longitudinal    <= valid_q ? thr_q : 16'sd0;
			out_q.steering        <= !valid_q ? 16'sd0 :
				(neg_q ? 16'(-16'(steer_q)) : 16'(steer_q));
			out_q.sequence_number <= count_q + 32'd1;
			out_q.sample_stamp    <= samp_q;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire
